// File: rtl/core/sign_invariant_vector_pair_metrics_defines.svh
// Assertion macros used by the checker file of the vector pair metrics block.
`ifndef SIGN_INVARIANT_VECTOR_PAIR_METRICS_DEFINES_SVH
`define SIGN_INVARIANT_VECTOR_PAIR_METRICS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SVPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SVPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/svpm_pkg.sv
// Shared widths, codes and item types of the vector pair metrics block.
`default_nettype none
package svpm_pkg;

    localparam int ELEM_W = 16;
    localparam int SUM_W  = 24;
    localparam int CNT_W  = 9;
    localparam int MAG_W  = 16;
    localparam int REL_W  = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [REL_W-1:0] REL_NONE    = 2'd0;
    localparam logic [REL_W-1:0] REL_EQUAL   = 2'd1;
    localparam logic [REL_W-1:0] REL_NEGATED = 2'd2;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a_elem;
        logic signed [ELEM_W-1:0] b_elem;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] canon_elem;
        logic                     done_res;
        logic [SUM_W-1:0]         l1_distance;
        logic [CNT_W-1:0]         hamming;
        logic [CNT_W-1:0]         matches_res;
        logic [CNT_W-1:0]         support;
        logic [MAG_W-1:0]         max_abs;
        logic [REL_W-1:0]         relation;
        logic                     less;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/core/svpm_in_if.sv
// Input channel carrying one element pair of the two vectors per item.
`default_nettype none
interface svpm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [svpm_pkg::ELEM_W-1:0]   a_elem;
    logic signed [svpm_pkg::ELEM_W-1:0]   b_elem;
    logic                                 last;

    modport source (output valid, output a_elem, output b_elem, output last, input ready);
    modport sink   (input valid, input a_elem, input b_elem, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/svpm_out_if.sv
// Output channel carrying the canonized element and the vector metrics per item.
`default_nettype none
interface svpm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [svpm_pkg::ELEM_W-1:0]   canon_elem;
    logic                                 done_res;
    logic [svpm_pkg::SUM_W-1:0]           l1_distance;
    logic [svpm_pkg::CNT_W-1:0]           hamming;
    logic [svpm_pkg::CNT_W-1:0]           matches_res;
    logic [svpm_pkg::CNT_W-1:0]           support;
    logic [svpm_pkg::MAG_W-1:0]           max_abs;
    logic [svpm_pkg::REL_W-1:0]           relation;
    logic                                 less;

    modport source (output valid, output canon_elem, output done_res, output l1_distance,
                    output hamming, output matches_res, output support, output max_abs,
                    output relation, output less, input ready);
    modport sink   (input valid, input canon_elem, input done_res, input l1_distance,
                    input hamming, input matches_res, input support, input max_abs,
                    input relation, input less, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sign_invariant_vector_pair_metrics.sv
// Top level: sign-invariant L1 / Hamming metrics over a streamed vector pair.
// An item passes the input register, then the result register, to the output.
// Throughput: one item per cycle unless stalled; accumulator update is a single stage.
// A stalled output holds the result register; one more item waits in the input register.
// Reset clears both valid bits and all accumulators; accumulators also clear after last.
`default_nettype none
module sign_invariant_vector_pair_metrics (
    input  logic        clk,
    input  logic        rst_n,
    svpm_in_if.sink     pairs,
    svpm_out_if.source  metrics
);

    logic                 s1_valid_reg;
    svpm_pkg::item_t      s1_item_reg;
    logic                 out_valid_reg;
    svpm_pkg::result_t    out_res_reg;
    svpm_pkg::result_t    res;
    logic                 advance;
    logic                 step;

    assign advance     = !out_valid_reg || metrics.ready;
    assign step        = s1_valid_reg && advance;
    assign pairs.ready = !s1_valid_reg || advance;

    svpm_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (s1_item_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pairs.ready)
            begin
                s1_valid_reg <= pairs.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pairs.valid && pairs.ready)
        begin
            s1_item_reg.a_elem <= pairs.a_elem;
            s1_item_reg.b_elem <= pairs.b_elem;
            s1_item_reg.last   <= pairs.last;
        end
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign metrics.valid       = out_valid_reg;
    assign metrics.canon_elem  = out_res_reg.canon_elem;
    assign metrics.done_res    = out_res_reg.done_res;
    assign metrics.l1_distance = out_res_reg.l1_distance;
    assign metrics.hamming     = out_res_reg.hamming;
    assign metrics.matches_res = out_res_reg.matches_res;
    assign metrics.support     = out_res_reg.support;
    assign metrics.max_abs     = out_res_reg.max_abs;
    assign metrics.relation    = out_res_reg.relation;
    assign metrics.less        = out_res_reg.less;

endmodule
`default_nettype wire

// File: rtl/core/svpm_accum.sv
// Per-vector accumulators and the result logic for one element pair.
`default_nettype none
module svpm_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  svpm_pkg::item_t   item,
    output svpm_pkg::result_t res
);

    logic [svpm_pkg::SUM_W-1:0]  l1d_reg, l1d_next;
    logic [svpm_pkg::SUM_W-1:0]  l1n_reg, l1n_next;
    logic [svpm_pkg::CNT_W-1:0]  mmd_reg, mmd_next;
    logic [svpm_pkg::CNT_W-1:0]  mmn_reg, mmn_next;
    logic [svpm_pkg::CNT_W-1:0]  mtd_reg, mtd_next;
    logic [svpm_pkg::CNT_W-1:0]  mtn_reg, mtn_next;
    logic [svpm_pkg::CNT_W-1:0]  nz_reg, nz_next;
    logic [svpm_pkg::MAG_W-1:0]  maxmag_reg, maxmag_next;
    logic                        eq_reg, eq_next;
    logic                        neg_reg, neg_next;
    logic                        ord_dec_reg, ord_dec_next;
    logic                        ord_less_reg, ord_less_next;
    logic                        sgn_found_reg, sgn_found_next;
    logic                        sgn_flip_reg, sgn_flip_next;

    logic signed [svpm_pkg::ELEM_W:0] diff;
    logic signed [svpm_pkg::ELEM_W:0] sum;
    logic [svpm_pkg::ELEM_W:0]        diff_mag;
    logic [svpm_pkg::ELEM_W:0]        sum_mag;
    logic [svpm_pkg::MAG_W-1:0]       a_mag;
    logic [svpm_pkg::SUM_W:0]         l1d_wide;
    logic [svpm_pkg::SUM_W:0]         l1n_wide;
    logic                             ne_direct;
    logic                             ne_negated;
    logic                             a_nz;

    function automatic logic [svpm_pkg::CNT_W-1:0] sat_inc(
        input logic [svpm_pkg::CNT_W-1:0] c,
        input logic                       cond
    );
        logic [svpm_pkg::CNT_W-1:0] r;
        r = c;
        if (cond && (c != svpm_pkg::CNT_MAX))
        begin
            r = c + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        diff      = {item.a_elem[svpm_pkg::ELEM_W-1], item.a_elem}
                  - {item.b_elem[svpm_pkg::ELEM_W-1], item.b_elem};
        sum       = {item.a_elem[svpm_pkg::ELEM_W-1], item.a_elem}
                  + {item.b_elem[svpm_pkg::ELEM_W-1], item.b_elem};
        diff_mag  = diff[svpm_pkg::ELEM_W] ? (-diff) : diff;
        sum_mag   = sum[svpm_pkg::ELEM_W] ? (-sum) : sum;
        a_mag     = item.a_elem[svpm_pkg::ELEM_W-1] ? (-item.a_elem) : item.a_elem;
        ne_direct  = (diff != '0);
        ne_negated = (sum != '0);
        a_nz       = (item.a_elem != '0);

        l1d_wide = {1'b0, l1d_reg} + (svpm_pkg::SUM_W+1)'(diff_mag);
        l1n_wide = {1'b0, l1n_reg} + (svpm_pkg::SUM_W+1)'(sum_mag);
        l1d_next = l1d_wide[svpm_pkg::SUM_W] ? svpm_pkg::SUM_MAX
                                             : l1d_wide[svpm_pkg::SUM_W-1:0];
        l1n_next = l1n_wide[svpm_pkg::SUM_W] ? svpm_pkg::SUM_MAX
                                             : l1n_wide[svpm_pkg::SUM_W-1:0];

        mmd_next = sat_inc(mmd_reg, ne_direct);
        mmn_next = sat_inc(mmn_reg, ne_negated);
        mtd_next = sat_inc(mtd_reg, a_nz && !ne_direct);
        mtn_next = sat_inc(mtn_reg, a_nz && !ne_negated);
        nz_next  = sat_inc(nz_reg, a_nz);

        maxmag_next = (a_mag > maxmag_reg) ? a_mag : maxmag_reg;
        eq_next     = eq_reg && !ne_direct;
        neg_next    = neg_reg && !ne_negated;

        ord_dec_next  = ord_dec_reg;
        ord_less_next = ord_less_reg;
        if (!ord_dec_reg && ne_direct)
        begin
            ord_dec_next  = 1'b1;
            ord_less_next = (item.a_elem < item.b_elem);
        end

        sgn_found_next = sgn_found_reg;
        sgn_flip_next  = sgn_flip_reg;
        if (!sgn_found_reg && a_nz)
        begin
            sgn_found_next = 1'b1;
            sgn_flip_next  = item.a_elem[svpm_pkg::ELEM_W-1];
        end
    end

    always_comb
    begin
        res = '0;
        if (!sgn_flip_next)
        begin
            res.canon_elem = item.a_elem;
        end
        else if (item.a_elem == {1'b1, {(svpm_pkg::ELEM_W-1){1'b0}}})
        begin
            res.canon_elem = {1'b0, {(svpm_pkg::ELEM_W-1){1'b1}}};
        end
        else
        begin
            res.canon_elem = -item.a_elem;
        end

        if (item.last)
        begin
            res.done_res    = 1'b1;
            res.l1_distance = (l1d_next < l1n_next) ? l1d_next : l1n_next;
            res.hamming     = (mmd_next < mmn_next) ? mmd_next : mmn_next;
            res.matches_res = (mtd_next > mtn_next) ? mtd_next : mtn_next;
            res.support     = nz_next;
            res.max_abs     = maxmag_next;
            res.relation    = eq_next  ? svpm_pkg::REL_EQUAL :
                              neg_next ? svpm_pkg::REL_NEGATED : svpm_pkg::REL_NONE;
            res.less        = ord_dec_next && ord_less_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1d_reg       <= '0;
            l1n_reg       <= '0;
            mmd_reg       <= '0;
            mmn_reg       <= '0;
            mtd_reg       <= '0;
            mtn_reg       <= '0;
            nz_reg        <= '0;
            maxmag_reg    <= '0;
            eq_reg        <= 1'b1;
            neg_reg       <= 1'b1;
            ord_dec_reg   <= 1'b0;
            ord_less_reg  <= 1'b0;
            sgn_found_reg <= 1'b0;
            sgn_flip_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (item.last)
            begin
                l1d_reg       <= '0;
                l1n_reg       <= '0;
                mmd_reg       <= '0;
                mmn_reg       <= '0;
                mtd_reg       <= '0;
                mtn_reg       <= '0;
                nz_reg        <= '0;
                maxmag_reg    <= '0;
                eq_reg        <= 1'b1;
                neg_reg       <= 1'b1;
                ord_dec_reg   <= 1'b0;
                ord_less_reg  <= 1'b0;
                sgn_found_reg <= 1'b0;
                sgn_flip_reg  <= 1'b0;
            end
            else
            begin
                l1d_reg       <= l1d_next;
                l1n_reg       <= l1n_next;
                mmd_reg       <= mmd_next;
                mmn_reg       <= mmn_next;
                mtd_reg       <= mtd_next;
                mtn_reg       <= mtn_next;
                nz_reg        <= nz_next;
                maxmag_reg    <= maxmag_next;
                eq_reg        <= eq_next;
                neg_reg       <= neg_next;
                ord_dec_reg   <= ord_dec_next;
                ord_less_reg  <= ord_less_next;
                sgn_found_reg <= sgn_found_next;
                sgn_flip_reg  <= sgn_flip_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/svpm_checker.sv
// Port-level checker for the vector pair metrics block, with its bind.
`default_nettype none
`include "sign_invariant_vector_pair_metrics_defines.svh"
module svpm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [svpm_pkg::ELEM_W-1:0] canon_elem,
    input logic                               done_res,
    input logic [svpm_pkg::SUM_W-1:0]         l1_distance,
    input logic [svpm_pkg::CNT_W-1:0]         hamming,
    input logic [svpm_pkg::CNT_W-1:0]         matches_res,
    input logic [svpm_pkg::CNT_W-1:0]         support,
    input logic [svpm_pkg::MAG_W-1:0]         max_abs,
    input logic [svpm_pkg::REL_W-1:0]         relation,
    input logic                               less
);

    `SVPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({canon_elem, done_res, l1_distance, hamming, matches_res, support, max_abs, relation, less}), "stalled result changed")
    `SVPM_ASSERT_SAME(a_metrics_zero, out_valid && !done_res, l1_distance == '0 && hamming == '0 && matches_res == '0 && support == '0 && max_abs == '0 && relation == svpm_pkg::REL_NONE && !less, "metrics set on a non-final item")
    `SVPM_ASSERT_SAME(a_rel_dist, out_valid && done_res && (relation == svpm_pkg::REL_EQUAL || relation == svpm_pkg::REL_NEGATED), hamming == '0 && l1_distance == '0, "relation disagrees with distances")
    `SVPM_ASSERT_SAME(a_match_support, out_valid && done_res, matches_res <= support && !(relation == svpm_pkg::REL_EQUAL && less), "matches or order inconsistent")

endmodule

bind sign_invariant_vector_pair_metrics svpm_checker u_svpm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (metrics.valid),
    .out_ready   (metrics.ready),
    .canon_elem  (metrics.canon_elem),
    .done_res    (metrics.done_res),
    .l1_distance (metrics.l1_distance),
    .hamming     (metrics.hamming),
    .matches_res (metrics.matches_res),
    .support     (metrics.support),
    .max_abs     (metrics.max_abs),
    .relation    (metrics.relation),
    .less        (metrics.less)
);
`default_nettype wire
